@@ design/mstg_pkg.sv @@
// ----------------------------------------------------------------------------
// mstg_pkg
// Shared types and constants for the merge-sum-to-goal cost block.
// ----------------------------------------------------------------------------
package mstg_pkg;

  localparam int MAX_ENTRIES = 1024;
  localparam int VALUE_BITS  = 16;
  localparam int ADDR_BITS   = 10;
  localparam int CNT_BITS    = 11;
  localparam int GOAL_BITS   = 12;
  localparam int UTIL_BITS   = 28;
  localparam int STEP_BITS   = 12;
  localparam int COST_BITS   = 27;
  localparam int DIV_BITS    = 32;

  // command codes of an input word
  localparam logic [1:0] CMD_LOAD_P     = 2'd0;
  localparam logic [1:0] CMD_LOAD_ORDER = 2'd1;
  localparam logic [1:0] CMD_LOAD_Q     = 2'd2;
  localparam logic [1:0] CMD_RUN        = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_P_COUNT = 2'd0;
  localparam logic [1:0] REG_Q_COUNT = 2'd1;
  localparam logic [1:0] REG_GOAL    = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ORD, ST_PTAB, ST_PCHK, ST_QRD, ST_QCHK,
    ST_STEP, ST_DSTART, ST_DIV, ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic p_end;
    logic p_skip;
    logic p_load;
    logic q_load;
    logic step;
    logic div_start;
    logic div_run;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic p_end;
    logic p_zero;
    logic none_left;
    logic hit;
    logic div_done;
  } status_t;

endpackage

@@ design/merge_sum_to_goal_cost_top.sv @@
// A load word is written in the cycle it is accepted, one per cycle while idle.
// A run reads, per merged value, the order, p and q entries (each registered),
// then takes the step; a skipped zero p entry repeats the order and p reads.
// The bit-serial correction division follows, and then the result is presented.
// Only one run is in flight; input is stalled until its result is taken.
// Reset (synchronous, rst_n low): controller idle, p_count=q_count=1024, goal=1.
// ----------------------------------------------------------------------------
// merge_sum_to_goal_cost_top
// Merges the p and q streams until the utility reaches goal or both streams run out, reports cost.
// ----------------------------------------------------------------------------
module merge_sum_to_goal_cost_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_write,
  input  logic [1:0]                      cfg_index,
  input  logic [mstg_pkg::GOAL_BITS-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_command,
  input  logic [mstg_pkg::ADDR_BITS-1:0]  in_address,
  input  logic [mstg_pkg::VALUE_BITS-1:0] in_probability,
  input  logic [mstg_pkg::CNT_BITS-1:0]   in_order_index,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [mstg_pkg::COST_BITS-1:0]  out_cost,
  output logic                            out_goal_reached
);
  import mstg_pkg::*;

  cmd_t    cmd;
  status_t st;
  logic    load_en;

  // load words are taken directly by the stores
  assign load_en = in_valid && !in_stall && in_command != CMD_RUN;

  mstg_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_command, .in_stall,
    .out_valid, .out_stall, .st, .cmd
  );

  mstg_dp u_dp (
    .clk, .rst_n, .cfg_write, .cfg_index, .cfg_data, .load_en,
    .in_command, .in_address, .in_probability, .in_order_index,
    .cmd, .st, .out_cost, .out_goal_reached
  );

endmodule

@@ design/mstg_ctrl.sv @@
// ----------------------------------------------------------------------------
// mstg_ctrl
// Sequencer: loads in idle, then the merge walk, division and result hold.
// ----------------------------------------------------------------------------
module mstg_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_command,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  mstg_pkg::status_t st,
  output mstg_pkg::cmd_t    cmd
);
  import mstg_pkg::*;

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid && in_command == CMD_RUN) state_nxt = ST_ORD;
      ST_ORD:    state_nxt = st.p_end ? ST_QRD : ST_PTAB;
      ST_PTAB:   state_nxt = ST_PCHK;
      ST_PCHK:   state_nxt = st.p_zero ? ST_ORD : ST_QRD;
      ST_QRD:    state_nxt = ST_QCHK;
      ST_QCHK:   state_nxt = ST_STEP;
      ST_STEP:   state_nxt = (st.none_left || st.hit) ? ST_DSTART : ST_ORD;
      ST_DSTART: state_nxt = ST_DIV;
      ST_DIV:    if (st.div_done) state_nxt = ST_OUT;
      ST_OUT:    if (!out_stall) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall  = 1'b0;
        cmd.start = in_valid && in_command == CMD_RUN;
      end
      ST_ORD:    cmd.p_end = st.p_end;
      ST_PCHK: begin
        cmd.p_skip = st.p_zero;
        cmd.p_load = !st.p_zero;
      end
      ST_QCHK:   cmd.q_load = 1'b1;
      ST_STEP:   cmd.step = !st.none_left;
      ST_DSTART: cmd.div_start = 1'b1;
      ST_DIV: begin
        cmd.div_run = !st.div_done;
        cmd.fin     = st.div_done;
      end
      ST_OUT:    out_valid = 1'b1;
      default:   cmd = '0;
    endcase
  end

  a_run_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_command == CMD_RUN) |=> in_stall)
    else $error("run accepted but input not stalled");
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall) |=> !out_valid)
    else $error("result repeated");
  a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input open while result pending");

endmodule

@@ design/mstg_dp.sv @@
// ----------------------------------------------------------------------------
// mstg_dp
// Datapath: stores, stream heads, utility accumulator, restoring divider.
// ----------------------------------------------------------------------------
module mstg_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_write,
  input  logic [1:0]                     cfg_index,
  input  logic [mstg_pkg::GOAL_BITS-1:0] cfg_data,
  input  logic                           load_en,
  input  logic [1:0]                     in_command,
  input  logic [mstg_pkg::ADDR_BITS-1:0] in_address,
  input  logic [mstg_pkg::VALUE_BITS-1:0] in_probability,
  input  logic [mstg_pkg::CNT_BITS-1:0]  in_order_index,
  input  mstg_pkg::cmd_t                 cmd,
  output mstg_pkg::status_t              st,
  output logic [mstg_pkg::COST_BITS-1:0] out_cost,
  output logic                           out_goal_reached
);
  import mstg_pkg::*;

  localparam logic [CNT_BITS-1:0] MAX_CNT = CNT_BITS'(MAX_ENTRIES);

  logic [VALUE_BITS-1:0] p_mem [MAX_ENTRIES];
  logic [CNT_BITS-1:0]   o_mem [MAX_ENTRIES];
  logic [VALUE_BITS-1:0] q_mem [MAX_ENTRIES];

  logic [CNT_BITS-1:0]   p_count_r, q_count_r;
  logic [GOAL_BITS-1:0]  goal_r;
  logic [CNT_BITS-1:0]   j_r, k_r;
  logic [CNT_BITS-1:0]   ord_q_r;
  logic                  pidx_ok_r;
  logic [VALUE_BITS-1:0] p_q_r, q_q_r;
  logic [VALUE_BITS-1:0] p_head_r, q_head_r, last_r;
  logic                  p_have_r, q_have_r, reached_r;
  logic [UTIL_BITS-1:0]  util_r;
  logic [STEP_BITS-1:0]  steps_r;
  logic [DIV_BITS-1:0]   dq_r;
  logic [VALUE_BITS-1:0] rem_r;
  logic [5:0]            cnt_r;
  logic [COST_BITS-1:0]  cost_r;
  logic                  goal_hit_r;

  logic [CNT_BITS-1:0]   m, n;
  logic [UTIL_BITS-1:0]  goal_q, util_add, excess;
  logic                  take_p;
  logic [VALUE_BITS-1:0] take_val;
  logic [VALUE_BITS:0]   rem_sh, rem_sub;
  logic                  ge;
  logic [VALUE_BITS:0]   frac;
  logic [UTIL_BITS-1:0]  steps_q, cost_full;
  logic [CNT_BITS-1:0]   pidx_m1;

  // saturated counts and goal in utility scale
  assign m      = (p_count_r > MAX_CNT) ? MAX_CNT : p_count_r;
  assign n      = (q_count_r > MAX_CNT) ? MAX_CNT : q_count_r;
  assign goal_q = {goal_r, {VALUE_BITS{1'b0}}};

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_count_r <= MAX_CNT;
      q_count_r <= MAX_CNT;
      goal_r    <= GOAL_BITS'(1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_P_COUNT: p_count_r <= cfg_data[CNT_BITS-1:0];
        REG_Q_COUNT: q_count_r <= cfg_data[CNT_BITS-1:0];
        REG_GOAL:    goal_r    <= cfg_data;
        default:     ;
      endcase
    end
  end

  // stores: written by loads, read every cycle at the stream positions
  assign pidx_m1 = ord_q_r - CNT_BITS'(1);
  always_ff @(posedge clk) begin
    if (load_en) begin
      unique case (in_command)
        CMD_LOAD_P:     p_mem[in_address] <= in_probability;
        CMD_LOAD_ORDER: o_mem[in_address] <= in_order_index;
        CMD_LOAD_Q:     q_mem[in_address] <= in_probability;
        default:        ;
      endcase
    end
    ord_q_r   <= o_mem[j_r[ADDR_BITS-1:0]];
    p_q_r     <= p_mem[pidx_m1[ADDR_BITS-1:0]];
    pidx_ok_r <= (ord_q_r != '0) && (ord_q_r <= MAX_CNT);
    q_q_r     <= q_mem[k_r[ADDR_BITS-1:0]];
  end

  // merge choice: larger head wins, tie goes to q
  assign take_p   = p_have_r && (!q_have_r || p_head_r > q_head_r);
  assign take_val = take_p ? p_head_r : q_head_r;
  assign util_add = util_r + UTIL_BITS'(take_val);
  assign excess   = util_r - goal_q;

  assign st.p_end     = j_r >= m;
  assign st.p_zero    = !pidx_ok_r || p_q_r == '0;
  assign st.none_left = !p_have_r && !q_have_r;
  assign st.hit       = util_add >= goal_q;
  assign st.div_done  = cnt_r == 6'(DIV_BITS);

  // restoring division step
  assign rem_sh  = {rem_r, dq_r[DIV_BITS-1]};
  assign ge      = rem_sh >= {1'b0, last_r};
  assign rem_sub = rem_sh - {1'b0, last_r};

  // final cost
  assign frac      = (last_r == '0) ? '0 : dq_r[VALUE_BITS:0];
  assign steps_q   = {steps_r, {VALUE_BITS{1'b0}}};
  assign cost_full = (steps_q >= UTIL_BITS'(frac)) ? steps_q - UTIL_BITS'(frac) : '0;

  // walk and divider registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      j_r      <= '0;
      k_r      <= '0;
      util_r   <= '0;
      steps_r  <= '0;
      last_r   <= '0;
    end
    if (cmd.p_end)  p_have_r <= 1'b0;
    if (cmd.p_skip) j_r <= j_r + CNT_BITS'(1);
    if (cmd.p_load) begin
      p_have_r <= 1'b1;
      p_head_r <= p_q_r;
    end
    if (cmd.q_load) begin
      q_have_r <= k_r < n;
      q_head_r <= q_q_r;
    end
    if (cmd.step) begin
      last_r  <= take_val;
      util_r  <= util_add;
      steps_r <= steps_r + STEP_BITS'(1);
      if (take_p) j_r <= j_r + CNT_BITS'(1);
      else        k_r <= k_r + CNT_BITS'(1);
    end
    if (cmd.div_start) begin
      dq_r       <= {excess[VALUE_BITS-1:0], {VALUE_BITS{1'b0}}};
      rem_r      <= '0;
      goal_hit_r <= util_r >= goal_q;
    end
    if (cmd.div_run) begin
      rem_r <= ge ? rem_sub[VALUE_BITS-1:0] : rem_sh[VALUE_BITS-1:0];
      dq_r  <= {dq_r[DIV_BITS-2:0], ge};
    end
    if (cmd.fin) begin
      reached_r <= goal_hit_r;
      if (!goal_hit_r)
        cost_r <= (m == '0) ? '0
                : COST_BITS'({m - CNT_BITS'(1), {VALUE_BITS{1'b0}}});
      else if (cost_full[UTIL_BITS-1])
        cost_r <= '1;
      else
        cost_r <= cost_full[COST_BITS-1:0];
    end
  end

  // division bit counter
  always_ff @(posedge clk) begin
    if (!rst_n)              cnt_r <= '0;
    else if (cmd.div_start)  cnt_r <= '0;
    else if (cmd.div_run)    cnt_r <= cnt_r + 6'd1;
  end

  assign out_cost         = cost_r;
  assign out_goal_reached = reached_r;

  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 6'(DIV_BITS))
    else $error("divider counter overran");
  a_fin_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |-> st.div_done)
    else $error("cost latched before division finished");
  a_step_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> (p_have_r || q_have_r))
    else $error("step with both streams empty");

endmodule
